// ----- design/tpb_pkg.sv -----
// ----------------------------------------------------------------------------
// tpb_pkg
// shared constants and types for the turtle plotter bitmap core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpb_pkg;

  // grid geometry
  localparam int GRID_SIZE = 64;
  localparam int ADDR_W    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int ROW_W     = 64;
  localparam int POS_W     = 6;
  localparam int WIDTH_W   = 7;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(GRID_SIZE - 1);

  // command codes
  localparam logic [2:0] OP_PEN_UP   = 3'd0;
  localparam logic [2:0] OP_PEN_DOWN = 3'd1;
  localparam logic [2:0] OP_RIGHT    = 3'd2;
  localparam logic [2:0] OP_LEFT     = 3'd3;
  localparam logic [2:0] OP_FORWARD  = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  // headings
  localparam logic [1:0] HD_EAST  = 2'd0;
  localparam logic [1:0] HD_SOUTH = 2'd1;
  localparam logic [1:0] HD_WEST  = 2'd2;
  localparam logic [1:0] HD_NORTH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD_STEP,
    ST_FWD_MARK,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } state_t;

endpackage

// ----- design/tpb_ram.sv -----
// ----------------------------------------------------------------------------
// tpb_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/turtle_plotter_bitmap_core.sv -----
// ----------------------------------------------------------------------------
// turtle_plotter_bitmap_core
// turtle-style plotter over a square bitmap held in a ram, one cell per step
// ----------------------------------------------------------------------------
// forward: over d cells the sequencer steps once per cell; with the pen down
//   each step is followed by a mark state (read-modify-write of one bitmap row
//   per cell through the single ram port pair); pen, turn and no-op items finish in idle
// read-out: rows 0..reach_y, each through an issue and a load state, plus output stalls
// throughput: one item at a time, in_ready only while the sequencer is idle
// reset: synchronous, active low; pose, pen and reach clear, the
//   bitmap reads as cleared through per-row valid bits, no clearing pass
`timescale 1ns / 1ps

module turtle_plotter_bitmap_core
  import tpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [5:0]         in_distance,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_row_bits,
  output logic [5:0]         out_row_index,
  output logic [WIDTH_W-1:0] out_used_width,
  output logic               out_row_last
);

  // sequencer
  state_t state_r, state_nxt;

  // turtle state
  logic [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [POS_W-1:0] reach_x_r, reach_x_nxt;
  logic [POS_W-1:0] reach_y_r, reach_y_nxt;
  logic             pen_down_r, pen_down_nxt;
  logic [1:0]       heading_r, heading_nxt;

  // remaining cells of a forward move, current read-out row
  logic [5:0]       count_r, count_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  // per-row valid bits stand in for clearing the bitmap
  logic [GRID_SIZE-1:0] rowv_r;
  logic                 rd_valid_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   out_row_bits_r;
  logic [5:0]         out_row_index_r;
  logic [WIDTH_W-1:0] out_used_width_r;
  logic               out_row_last_r;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  // step unit and helpers
  logic [POS_W-1:0]   step_x, step_y;
  logic [ROW_W-1:0]   rd_row;
  logic [WIDTH_W-1:0] used_width;
  logic [ROW_W-1:0]   width_mask;
  logic               out_free;
  logic               row_is_last;
  logic               load_out;

  tpb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GRID_SIZE)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a row never written reads as empty
  assign rd_row      = rd_valid_r ? ram_rdata : '0;
  assign used_width  = WIDTH_W'(reach_x_r) + WIDTH_W'(1);
  // shifting by 64 gives zero, so a full width gives all ones
  assign width_mask  = ~({ROW_W{1'b1}} << used_width);
  assign out_free    = !out_valid_r || out_ready;
  assign row_is_last = (row_r == reach_y_r);

  // one clamped step along the heading
  always_comb begin
    step_x = pos_x_r;
    step_y = pos_y_r;
    case (heading_r)
      HD_EAST:  step_x = (pos_x_r == POS_MAX) ? pos_x_r : pos_x_r + POS_W'(1);
      HD_SOUTH: step_y = (pos_y_r == POS_MAX) ? pos_y_r : pos_y_r + POS_W'(1);
      HD_WEST:  step_x = (pos_x_r == '0) ? pos_x_r : pos_x_r - POS_W'(1);
      HD_NORTH: step_y = (pos_y_r == '0) ? pos_y_r : pos_y_r - POS_W'(1);
      default:  step_x = pos_x_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_FORWARD && in_distance != '0) begin
            state_nxt = ST_FWD_STEP;
          end else if (in_op == OP_READ) begin
            state_nxt = ST_RD_ISSUE;
          end
        end
      end
      ST_FWD_STEP: begin
        // pen down needs the mark cycle, else the move ends on the last cell
        if (pen_down_r) begin
          state_nxt = ST_FWD_MARK;
        end else if (count_r == 6'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FWD_MARK: begin
        state_nxt = (count_r == '0) ? ST_IDLE : ST_FWD_STEP;
      end
      ST_RD_ISSUE: begin
        state_nxt = ST_RD_LOAD;
      end
      ST_RD_LOAD: begin
        // wait here until the output register can take the row
        if (out_free) begin
          state_nxt = row_is_last ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    reach_x_nxt  = reach_x_r;
    reach_y_nxt  = reach_y_r;
    pen_down_nxt = pen_down_r;
    heading_nxt  = heading_r;
    count_nxt    = count_r;
    row_nxt      = row_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_y_r[ADDR_W-1:0];
    ram_wdata    = rd_row | (ROW_W'(1) << pos_x_r);
    ram_re       = 1'b0;
    ram_raddr    = row_r[ADDR_W-1:0];
    load_out     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_PEN_UP:   pen_down_nxt = 1'b0;
            OP_PEN_DOWN: pen_down_nxt = 1'b1;
            OP_RIGHT:    heading_nxt  = heading_r + 2'd1;
            OP_LEFT:     heading_nxt  = heading_r + 2'd3;
            OP_FORWARD:  count_nxt    = in_distance;
            OP_READ:     row_nxt      = '0;
            default:     count_nxt    = count_r;
          endcase
        end
      end
      ST_FWD_STEP: begin
        pos_x_nxt = step_x;
        pos_y_nxt = step_y;
        if (step_x > reach_x_r) begin
          reach_x_nxt = step_x;
        end
        if (step_y > reach_y_r) begin
          reach_y_nxt = step_y;
        end
        count_nxt = count_r - 6'd1;
        // fetch the row of the new cell for the mark cycle
        if (pen_down_r) begin
          ram_re    = 1'b1;
          ram_raddr = step_y[ADDR_W-1:0];
        end
      end
      ST_FWD_MARK: begin
        ram_we = 1'b1;
      end
      ST_RD_ISSUE: begin
        ram_re = 1'b1;
      end
      ST_RD_LOAD: begin
        if (out_free) begin
          load_out = 1'b1;
          if (!row_is_last) begin
            row_nxt = row_r + POS_W'(1);
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      reach_x_r   <= '0;
      reach_y_r   <= '0;
      pen_down_r  <= 1'b0;
      heading_r   <= HD_EAST;
      count_r     <= '0;
      row_r       <= '0;
      rowv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      reach_x_r   <= reach_x_nxt;
      reach_y_r   <= reach_y_nxt;
      pen_down_r  <= pen_down_nxt;
      heading_r   <= heading_nxt;
      count_r     <= count_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        rowv_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid_r <= rowv_r[ram_raddr];
    end
    if (load_out) begin
      out_row_bits_r   <= rd_row & width_mask;
      out_row_index_r  <= row_r;
      out_used_width_r <= used_width;
      out_row_last_r   <= row_is_last;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_row_bits   = out_row_bits_r;
  assign out_row_index  = out_row_index_r;
  assign out_used_width = out_used_width_r;
  assign out_row_last   = out_row_last_r;

endmodule

// ----- tb/turtle_plotter_bitmap_core_tb.sv -----
// ----------------------------------------------------------------------------
// turtle_plotter_bitmap_core_tb
// self-checking bench: drives pen, turn, forward and read-out commands,
// mirrors the plotter pose and bitmap in a scoreboard, and checks every row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module turtle_plotter_bitmap_core_tb;
  import tpb_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  // one expected read-out row
  typedef struct {
    logic [ROW_W-1:0]   bits;
    logic [5:0]         idx;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } plot_row_t;

  // mirror of the plotter: pose, pen, reach and bitmap, plus rows still due
  class plot_tracker;
    logic [ROW_W-1:0] canvas [GRID_SIZE];
    logic [POS_W-1:0] pos_x, pos_y, reach_x, reach_y;
    logic             pen;
    logic [1:0]       heading;
    plot_row_t        rows_due [$];
    int               errors;

    function new();
      foreach (canvas[i]) canvas[i] = '0;
      pos_x = '0; pos_y = '0; reach_x = '0; reach_y = '0;
      pen = 1'b0; heading = HD_EAST;
      errors = 0;
    endfunction

    task flag(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void apply_command(input logic [2:0] op, input logic [5:0] move_len);
      logic [WIDTH_W-1:0] width;
      logic [ROW_W-1:0]   mask;
      plot_row_t          row;
      case (op)
        OP_PEN_UP:   pen = 1'b0;
        OP_PEN_DOWN: pen = 1'b1;
        OP_RIGHT:    heading = heading + 2'd1;
        OP_LEFT:     heading = heading - 2'd1;
        OP_FORWARD: begin
          for (int i = 0; i < move_len; i++) begin
            // clamp at the grid edge, the step still counts
            case (heading)
              HD_EAST:  if (pos_x < POS_MAX) pos_x++;
              HD_SOUTH: if (pos_y < POS_MAX) pos_y++;
              HD_WEST:  if (pos_x > 0) pos_x--;
              default:  if (pos_y > 0) pos_y--;
            endcase
            if (pos_x > reach_x) reach_x = pos_x;
            if (pos_y > reach_y) reach_y = pos_y;
            if (pen) canvas[pos_y][pos_x] = 1'b1;
          end
        end
        OP_READ: begin
          width = WIDTH_W'(reach_x) + 7'd1;
          mask  = (width == 7'd64) ? '1 : ((64'd1 << width) - 64'd1);
          for (int r = 0; r <= reach_y; r++) begin
            row.bits  = canvas[r] & mask;
            row.idx   = 6'(r);
            row.width = width;
            row.last  = (r == reach_y);
            rows_due.push_back(row);
          end
        end
        default: ;
      endcase
    endfunction

    task check_row(input logic [ROW_W-1:0] bits, input logic [5:0] idx,
                   input logic [WIDTH_W-1:0] width, input logic last);
      plot_row_t want;
      if (rows_due.size() == 0) begin
        flag($sformatf("row %0d arrived with none expected", idx));
        return;
      end
      want = rows_due.pop_front();
      if (bits !== want.bits)
        flag($sformatf("row %0d bits %h, want %h", want.idx, bits, want.bits));
      if (idx !== want.idx)
        flag($sformatf("row index %0d, want %0d", idx, want.idx));
      if (width !== want.width)
        flag($sformatf("row %0d width %0d, want %0d", want.idx, width, want.width));
      if (last !== want.last)
        flag($sformatf("row %0d last %b, want %b", want.idx, last, want.last));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_op;
  logic [5:0]         in_distance;
  logic               out_valid;
  logic               out_ready;
  logic [ROW_W-1:0]   out_row_bits;
  logic [5:0]         out_row_index;
  logic [WIDTH_W-1:0] out_used_width;
  logic               out_row_last;

  plot_tracker sb;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_toggle;

  turtle_plotter_bitmap_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_distance    (in_distance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_bits   (out_row_bits),
    .out_row_index  (out_row_index),
    .out_used_width (out_used_width),
    .out_row_last   (out_row_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("turtle_plotter_bitmap_core test failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked for
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // every accepted row goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_row(out_row_bits, out_row_index, out_used_width, out_row_last);
  end

  // offer one item, with random idle cycles ahead of it; valid stays up afterwards
  task automatic send_item(input logic [2:0] op, input logic [5:0] move_len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_distance = move_len;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.apply_command(op, move_len);
    @(negedge clk);
  endtask

  // random commands, mostly pen-down walks with short moves and some read-outs
  task automatic run_random(input int count);
    int          pick;
    logic [2:0]  op;
    logic [5:0]  move_len;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      move_len = 6'($urandom_range(63));
      if      (pick < 10) op = OP_PEN_UP;
      else if (pick < 28) op = OP_PEN_DOWN;
      else if (pick < 40) op = OP_RIGHT;
      else if (pick < 52) op = OP_LEFT;
      else if (pick < 84) op = OP_FORWARD;
      else if (pick < 94) op = OP_READ;
      else if (pick < 97) op = 3'd6;
      else                op = 3'd7;
      // short moves keep the reach growing slowly, a few long ones hit the edges
      if (op == OP_FORWARD && $urandom_range(9) != 0)
        move_len = 6'($urandom_range(9));
      send_item(op, move_len);
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_PEN_UP;
    in_distance   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_toggle   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty read-out, unused codes, zero move, edge clamps, full width
    send_item(OP_READ, 6'd0);
    send_item(3'd6, 6'd63);
    send_item(3'd7, 6'd42);
    send_item(OP_PEN_DOWN, 6'd0);
    send_item(OP_FORWARD, 6'd0);
    send_item(OP_FORWARD, 6'd3);
    send_item(OP_RIGHT, 6'd0);
    send_item(OP_FORWARD, 6'd2);
    send_item(OP_READ, 6'd0);
    send_item(OP_RIGHT, 6'd0);
    send_item(OP_FORWARD, 6'd10);   // runs into the west edge
    send_item(OP_RIGHT, 6'd0);
    send_item(OP_FORWARD, 6'd5);    // runs into the north edge
    send_item(OP_LEFT, 6'd0);
    send_item(OP_LEFT, 6'd0);
    send_item(OP_LEFT, 6'd0);
    send_item(OP_PEN_UP, 6'd0);
    send_item(OP_FORWARD, 6'd1);
    send_item(OP_READ, 6'd0);
    send_item(OP_PEN_DOWN, 6'd0);
    send_item(OP_FORWARD, 6'd63);   // runs into the east edge, width 64
    send_item(OP_READ, 6'd63);
    send_item(OP_PEN_UP, 6'd0);

    // random phases with different idle patterns
    run_random(90);
    send_idle_pct = 79;
    stall_pct     = 0;
    run_random(90);
    send_idle_pct = 0;
    stall_pct     = 79;
    run_random(90);
    send_idle_pct = 15;
    stall_pct     = 15;
    run_random(90);

    // back-pressure: receiver holds off while items keep coming
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_toggle   = ~hold_toggle;
    send_item(OP_READ, 6'd0);
    run_random(24);
    in_valid = 1'b0;

    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("turtle_plotter_bitmap_core test passed");
    else
      $display("turtle_plotter_bitmap_core test failed");
    $finish;
  end

endmodule
